### rtl/sstf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF disk scheduler package
// Field widths, saturation limits and sequencer state codes shared by the
// scheduler files.
// ----------------------------------------------------------------------------
package sstf_pkg;

   // Fixed field widths of the stream items.
   localparam int CYL_FIELD_W  = 12;
   localparam int HOP_W        = 12;
   localparam int TOTAL_W      = 18;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_FIELDS_W = CYL_FIELD_W + HOP_W + TOTAL_W;
   localparam int RSP_DATA_W   = 48;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;
   localparam int REQ_PAD_W    = REQ_DATA_W - CYL_FIELD_W;

   localparam logic [HOP_W-1:0]   HOP_MAX   = 12'd4095;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 18'd262143;

   typedef logic [1:0] state_type;

   localparam state_type ST_LOAD  = 2'd0;
   localparam state_type ST_SCAN  = 2'd1;
   localparam state_type ST_DRAIN = 2'd2;
   localparam state_type ST_EMIT  = 2'd3;

   // One result item before packing.
   typedef struct packed {
      logic [TOTAL_W-1:0]     total_movement;
      logic [HOP_W-1:0]       hop_distance;
      logic [CYL_FIELD_W-1:0] served_cylinder;
   } result_type;

endpackage

### rtl/sstf_disk_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF disk scheduler
// Collects a batch of cylinder requests and serves them nearest-first.
// ----------------------------------------------------------------------------
// Requests are loaded one item per cycle into a request RAM; requests beyond
// MAX_REQUESTS are dropped. The item with tlast set is stored as well and
// starts service from the csr start cylinder. For each pick the scan reads
// every stored entry, one per cycle, through the single RAM read port, a
// drain state lets the compare stage finish and an emit state updates the
// head and loads the result register. A stalled result side holds the pick
// until the result register frees up. No new request is taken while a batch
// is in service; the result register lets the next batch load while the
// last result still waits.
module sstf_disk_scheduler_unit
   import sstf_pkg::*;
#(
   parameter int MAX_REQUESTS  = 32,
   parameter int CYLINDER_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request item: [11:0] request_cylinder, upper bits zero.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tlast,
   // Result item: [11:0] served_cylinder, [23:12] hop_distance,
   // [41:24] total_movement, upper bits zero.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast,
   // Start cylinder register write.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CYL_FIELD_W-1:0] csr_data
);
   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int CYL_W = CYLINDER_BITS;
   localparam int EXT_W = CYLINDER_BITS + CYL_FIELD_W;

   state_type               state_ff, state_in;
   logic [CYL_W-1:0]        start_ff, start_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [MAX_REQUESTS-1:0] served_ff, served_in;
   logic [CYL_W-1:0]        head_ff, head_in;
   logic [TOTAL_W-1:0]      sum_ff, sum_in;
   logic [IDX_W-1:0]        scan_ff, scan_in;
   logic [IDX_W-1:0]        pick_ff, pick_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [CYL_W-1:0]        best_dist_ff, best_dist_in;
   logic [CYL_W-1:0]        best_cyl_ff, best_cyl_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    ram_we;
   logic                    ram_re;
   logic [CYL_W-1:0]        ram_rd_data;
   logic [CYL_W-1:0]        req_cyl;
   logic [CNT_W-1:0]        count_m1;
   logic [IDX_W-1:0]        last_idx;
   logic [CYL_W-1:0]        rd_dist;
   logic [EXT_W-1:0]        best_dist_ext;
   logic [EXT_W-1:0]        best_cyl_ext;
   logic [HOP_W-1:0]        hop_sat;
   logic [TOTAL_W:0]        sum_wide;
   logic [TOTAL_W-1:0]      sum_next;
   logic                    out_free;

   // Cylinder values are cut or zero-extended to the configured cylinder width.
   assign req_cyl  = CYL_W'(EXT_W'(req_tdata[CYL_FIELD_W-1:0]));
   assign count_m1 = count_ff - CNT_W'(1);
   assign last_idx = count_m1[IDX_W-1:0];

   assign rd_dist = (head_ff > ram_rd_data) ? (head_ff - ram_rd_data)
                                            : (ram_rd_data - head_ff);

   assign best_dist_ext = EXT_W'(best_dist_ff);
   assign best_cyl_ext  = EXT_W'(best_cyl_ff);
   assign hop_sat  = (best_dist_ext > EXT_W'(HOP_MAX)) ? HOP_MAX
                                                       : best_dist_ext[HOP_W-1:0];
   // The running total accumulates the unclipped hop and saturates on its own.
   assign sum_wide = (TOTAL_W+1)'(sum_ff) + (TOTAL_W+1)'(best_dist_ff);
   assign sum_next = (sum_wide > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : sum_wide[TOTAL_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;

   sstf_ram #(
      .WIDTH (CYL_W),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_cyl),
      .rd_en   (ram_re),
      .rd_addr (scan_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      served_in    = served_ff;
      head_in      = head_ff;
      sum_in       = sum_ff;
      scan_in      = scan_ff;
      pick_in      = pick_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      best_cyl_in  = best_cyl_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         start_in = CYL_W'(EXT_W'(csr_data));
      end

      // Compare stage: strict less-than keeps the earliest entry on a tie.
      if (rd_vld_ff && !served_ff[rd_idx_ff] && (!found_ff || rd_dist < best_dist_ff)) begin
         found_in     = 1'b1;
         best_idx_in  = rd_idx_ff;
         best_dist_in = rd_dist;
         best_cyl_in  = ram_rd_data;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (count_ff < CNT_W'(MAX_REQUESTS)) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  head_in  = start_ff;
                  sum_in   = '0;
                  pick_in  = '0;
                  scan_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ram_re    = 1'b1;
            rd_vld_in = 1'b1;
            rd_idx_in = scan_ff;
            if (scan_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.served_cylinder = best_cyl_ext[CYL_FIELD_W-1:0];
               rsp_data_in.hop_distance    = hop_sat;
               rsp_data_in.total_movement  = sum_next;
               rsp_last_in                 = (pick_ff == last_idx);
               served_in[best_idx_ff]      = 1'b1;
               head_in                     = best_cyl_ff;
               sum_in                      = sum_next;
               if (pick_ff == last_idx) begin
                  count_in  = '0;
                  served_in = '0;
                  state_in  = ST_LOAD;
               end else begin
                  pick_in  = pick_ff + IDX_W'(1);
                  scan_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         start_ff     <= '0;
         count_ff     <= '0;
         served_ff    <= '0;
         head_ff      <= '0;
         sum_ff       <= '0;
         scan_ff      <= '0;
         pick_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         served_ff    <= served_in;
         head_ff      <= head_in;
         sum_ff       <= sum_in;
         scan_ff      <= scan_in;
         pick_ff      <= pick_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      best_cyl_ff  <= best_cyl_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Pad bits of the request item carry nothing.
   logic [REQ_PAD_W-1:0] req_pad_unused;
   assign req_pad_unused = req_tdata[REQ_DATA_W-1:CYL_FIELD_W];

endmodule

### rtl/sstf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sstf_ram #(
   parameter int  WIDTH  = 12,
   parameter int  DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
